/* hdl/sliding_window_median_assert.svh */
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// consequence must hold in the cycle after the antecedent
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define SWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/swm_pkg.sv */
package swm_pkg;

    // default sizes
    localparam int DEF_MAX_WINDOW  = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    // window length register
    localparam int               CFG_W         = 7;
    localparam logic [CFG_W-1:0] CFG_LEN_RESET = 7'd3;

    // cells per group in the first level of the median pick
    localparam int SEL_GRP = 8;

    // link handed from one cell to the next one up
    typedef struct packed {
        logic le;         // this cell's kept entry is <= the new sample
        logic past_drop;  // the dropped entry sits at or below this cell
    } t_link;

endpackage

/* hdl/swm_cell.sv */
module swm_cell #(
    parameter int VAL_W = 32,
    parameter int AGE_W = 6,
    parameter int LEN_W = 7,
    parameter int IDX   = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_full,
    input  logic                      i_none_found,
    input  logic [LEN_W-1:0]          i_fill_eff,
    input  logic [LEN_W-1:0]          i_fill_m1,
    input  logic [LEN_W-1:0]          i_keep,
    input  logic [LEN_W-1:0]          i_len_m1,
    input  logic signed [VAL_W-1:0]   i_sample,
    input  swm_pkg::t_link            i_link,
    input  logic signed [VAL_W-1:0]   i_lo_cval,
    input  logic [AGE_W-1:0]          i_lo_cage,
    input  logic signed [VAL_W-1:0]   i_up_val,
    input  logic [AGE_W-1:0]          i_up_age,
    output swm_pkg::t_link            o_link,
    output logic signed [VAL_W-1:0]   o_cval,
    output logic [AGE_W-1:0]          o_cage,
    output logic signed [VAL_W-1:0]   o_val,
    output logic [AGE_W-1:0]          o_age,
    output logic                      o_match
);
    import swm_pkg::*;

    localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

    logic signed [VAL_W-1:0] r_val, n_val;
    logic [AGE_W-1:0]        r_age, n_age;
    logic                    drop, pd, le;

    // oldest entry lives here when the window is full
    assign o_match = i_full && (MY_IDX < i_fill_eff) && (LEN_W'(r_age) == i_len_m1);
    assign drop    = o_match || (i_full && i_none_found && (MY_IDX == i_fill_m1));
    assign pd      = i_link.past_drop | drop;

    // entry after removing the oldest one, aged by one
    assign o_cval = pd ? i_up_val : r_val;
    assign o_cage = (pd ? i_up_age : r_age) + AGE_W'(1);

    // new sample goes after every kept entry that is <= it
    assign le     = (MY_IDX < i_keep) && (o_cval <= i_sample);
    assign o_link = '{le: le, past_drop: pd};

    always_comb begin
        if (le) begin
            n_val = o_cval;
            n_age = o_cage;
        end else if (i_link.le) begin
            n_val = i_sample;
            n_age = '0;
        end else begin
            n_val = i_lo_cval;
            n_age = i_lo_cage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val <= n_val;
            r_age <= n_age;
        end
    end

    assign o_val = r_val;
    assign o_age = r_age;

endmodule

/* hdl/swm_median_sel.sv */
module swm_median_sel #(
    parameter int VAL_W = 32,
    parameter int N     = 64,
    parameter int IDX_W = 6
) (
    input  logic                    i_clk,
    input  logic signed [VAL_W-1:0] i_vals [N],
    input  logic [IDX_W-1:0]        i_idx_lo,
    input  logic [IDX_W-1:0]        i_idx_hi,
    output logic signed [VAL_W-1:0] o_lo,
    output logic signed [VAL_W-1:0] o_hi
);
    import swm_pkg::*;

    localparam int NGRP   = (N + SEL_GRP - 1) / SEL_GRP;
    localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int SUB_W  = $clog2(SEL_GRP);
    localparam int WX     = IDX_W + SUB_W;

    logic [WX-1:0]           lo_x, hi_x;
    logic [SUB_W-1:0]        lo_sub, hi_sub;
    logic [GIDX_W-1:0]       lo_grp, hi_grp;
    logic [GIDX_W-1:0]       r_lo_grp, r_hi_grp;
    logic signed [VAL_W-1:0] n_g_lo [NGRP];
    logic signed [VAL_W-1:0] n_g_hi [NGRP];
    logic signed [VAL_W-1:0] r_g_lo [NGRP];
    logic signed [VAL_W-1:0] r_g_hi [NGRP];
    logic signed [VAL_W-1:0] n_lo, n_hi;
    logic signed [VAL_W-1:0] r_lo, r_hi;

    // split indexes into group and place within group
    assign lo_x   = WX'(i_idx_lo);
    assign hi_x   = WX'(i_idx_hi);
    assign lo_sub = lo_x[SUB_W-1:0];
    assign hi_sub = hi_x[SUB_W-1:0];
    assign lo_grp = GIDX_W'(lo_x >> SUB_W);
    assign hi_grp = GIDX_W'(hi_x >> SUB_W);

    // first level: one pick inside every group
    always_comb begin
        int j;
        for (int g = 0; g < NGRP; g++) begin
            n_g_lo[g] = '0;
            n_g_hi[g] = '0;
            for (int k = 0; k < SEL_GRP; k++) begin
                j = g * SEL_GRP + k;
                if (j < N) begin
                    if (lo_sub == SUB_W'(k)) n_g_lo[g] = i_vals[j];
                    if (hi_sub == SUB_W'(k)) n_g_hi[g] = i_vals[j];
                end
            end
        end
    end

    // second level: pick among the group results
    always_comb begin
        n_lo = '0;
        n_hi = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_lo_grp == GIDX_W'(g)) n_lo = r_g_lo[g];
            if (r_hi_grp == GIDX_W'(g)) n_hi = r_g_hi[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_lo   <= n_g_lo;
        r_g_hi   <= n_g_hi;
        r_lo_grp <= lo_grp;
        r_hi_grp <= hi_grp;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

/* hdl/sliding_window_median.sv */
// channel   direction  handshake                  payload
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_window_len
// in        in         i_in_valid / o_in_ready    i_sample, i_stream_start
// out       out        o_out_valid / i_out_ready  o_median_doubled
//
// a sample is taken only while idle and is worked on before the next: cell row update in the
// accept cycle, median pick in ST_SEL1 and ST_SEL2, then the add into the output register in ST_OUT.
// a new sample is taken while a result waits in the output register; a result
// that finds that register still full holds the block until it is taken.
// window_len is written only while idle, ahead of a waiting sample.
// synchronous active-low reset clears control state and sets window_len to 3.
module sliding_window_median #(
    parameter int MAX_WINDOW  = swm_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [swm_pkg::CFG_W-1:0]    i_cfg_window_len,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                         i_stream_start,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [SAMPLE_BITS:0]  o_median_doubled
);
    import swm_pkg::*;

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int IDX_W = AGE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEL1 = 2'd1;
    localparam logic [1:0] ST_SEL2 = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_win;
    logic [LEN_W-1:0] r_fill;
    logic             r_emit;
    logic             r_out_valid;
    logic signed [SAMPLE_BITS:0] r_out;

    logic             accept, cfg_wr, load_out;
    logic [LEN_W-1:0] len_eff, len_m1, fill_eff, fill_m1, keep, new_fill;
    logic             full, none_found;
    logic [IDX_W-1:0] idx_lo, idx_hi;

    logic signed [SAMPLE_BITS-1:0] w_val  [MAX_WINDOW];
    logic [AGE_W-1:0]              w_age  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_cval [MAX_WINDOW];
    logic [AGE_W-1:0]              w_cage [MAX_WINDOW];
    t_link                         w_link [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         w_match;
    logic signed [SAMPLE_BITS-1:0] med_lo, med_hi;

    // window writes only while idle, and ahead of a sample in the same cycle
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign accept      = i_in_valid && o_in_ready;

    // window length in use: zero counts as one, saturate at the cell count
    always_comb begin
        if (r_win == '0) begin
            len_eff = LEN_W'(1);
        end else if (int'(r_win) > MAX_WINDOW) begin
            len_eff = LEN_W'(MAX_WINDOW);
        end else begin
            len_eff = LEN_W'(r_win);
        end
    end

    // fill bookkeeping for the sample being taken
    assign len_m1     = len_eff - LEN_W'(1);
    assign fill_eff   = (i_stream_start || (r_fill > len_eff)) ? '0 : r_fill;
    assign fill_m1    = fill_eff - LEN_W'(1);
    assign full       = (fill_eff == len_eff);
    assign keep       = full ? len_m1 : fill_eff;
    assign new_fill   = keep + LEN_W'(1);
    assign none_found = ~(|w_match);

    // row of sorting cells
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
        t_link                         lo_link;
        logic signed [SAMPLE_BITS-1:0] lo_cval, up_val;
        logic [AGE_W-1:0]              lo_cage, up_age;

        if (i == 0) begin : g_first
            assign lo_link = '{le: 1'b1, past_drop: 1'b0};
            assign lo_cval = '0;
            assign lo_cage = '0;
        end else begin : g_mid
            assign lo_link = w_link[i-1];
            assign lo_cval = w_cval[i-1];
            assign lo_cage = w_cage[i-1];
        end

        if (i == MAX_WINDOW - 1) begin : g_last
            assign up_val = w_val[i];
            assign up_age = w_age[i];
        end else begin : g_below
            assign up_val = w_val[i+1];
            assign up_age = w_age[i+1];
        end

        swm_cell #(
            .VAL_W (SAMPLE_BITS),
            .AGE_W (AGE_W),
            .LEN_W (LEN_W),
            .IDX   (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_en         (accept),
            .i_full       (full),
            .i_none_found (none_found),
            .i_fill_eff   (fill_eff),
            .i_fill_m1    (fill_m1),
            .i_keep       (keep),
            .i_len_m1     (len_m1),
            .i_sample     (i_sample),
            .i_link       (lo_link),
            .i_lo_cval    (lo_cval),
            .i_lo_cage    (lo_cage),
            .i_up_val     (up_val),
            .i_up_age     (up_age),
            .o_link       (w_link[i]),
            .o_cval       (w_cval[i]),
            .o_cage       (w_cage[i]),
            .o_val        (w_val[i]),
            .o_age        (w_age[i]),
            .o_match      (w_match[i])
        );
    end

    // middle positions of the window
    assign idx_lo = IDX_W'(len_m1 >> 1);
    assign idx_hi = IDX_W'(len_eff >> 1);

    swm_median_sel #(
        .VAL_W (SAMPLE_BITS),
        .N     (MAX_WINDOW),
        .IDX_W (IDX_W)
    ) u_sel (
        .i_clk    (i_clk),
        .i_vals   (w_val),
        .i_idx_lo (idx_lo),
        .i_idx_hi (idx_hi),
        .o_lo     (med_lo),
        .o_hi     (med_hi)
    );

    // sequencer
    assign load_out = (r_state == ST_OUT) && r_emit && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_SEL1;
            ST_SEL1: n_state = ST_SEL2;
            ST_SEL2: n_state = ST_OUT;
            ST_OUT:  if (!r_emit || load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win       <= CFG_LEN_RESET;
            r_fill      <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_win  <= i_cfg_window_len;
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= new_fill;
            end
            if (accept) begin
                r_emit <= (new_fill == len_eff);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // doubled median: sum of the two middle entries
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= {med_lo[SAMPLE_BITS-1], med_lo} + {med_hi[SAMPLE_BITS-1], med_hi};
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_median_doubled = r_out;

endmodule

/* hdl/swm_checker.sv */
`include "sliding_window_median_assert.svh"

module swm_checker #(
    parameter int SAMPLE_BITS = swm_pkg::DEF_SAMPLE_BITS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [swm_pkg::CFG_W-1:0]     i_cfg_window_len,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic                          i_stream_start,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS:0]   o_median_doubled
);
    // a taken sample keeps the input side closed while it is worked on
    `SWM_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "ready after accept")

    // a result only appears at the end of a sample's work
    `SWM_ASSERT_NOW(a_result_after_work, $rose(o_out_valid), $past(!o_in_ready), "early result")

    // a stalled result holds
    `SWM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_median_doubled), "stalled result changed")

    // a waiting sample request holds
    `SWM_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready,
        i_in_valid && $stable(i_sample) && $stable(i_stream_start), "sample request changed")

    // a waiting window write holds
    `SWM_ASSERT_NEXT(a_cfg_hold, i_cfg_valid && !o_cfg_ready,
        i_cfg_valid && $stable(i_cfg_window_len), "window write changed")

endmodule

bind sliding_window_median swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);
